[hdl/line_follower_mode_controller_top_macros.svh]
// Assertion macros used by the line follower mode controller RTL.
`ifndef LINE_FOLLOWER_MODE_CONTROLLER_TOP_MACROS_SVH
`define LINE_FOLLOWER_MODE_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define LFMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfmc assertion failed");

`define LFMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfmc assertion failed");

`else

`define LFMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define LFMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/lfmc_pkg.sv]
// Types, constants and the drive table of the line follower mode controller.
package lfmc_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int FRAC_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int SEC_W = 9;
    localparam int REST_W = 8;
    localparam int DIST_W = 12;
    localparam int DRIVE_W = 12;
    localparam int STOP_W = 8;

    localparam logic [1:0] CFG_OBST_EN = 2'd0;
    localparam logic [1:0] CFG_OBST_MM = 2'd1;
    localparam logic [1:0] CFG_NEAR_MM = 2'd2;
    localparam logic [1:0] CFG_STOP_S  = 2'd3;

    typedef enum logic [2:0] {
        M_TRACK = 3'd0,
        M_TURN  = 3'd1,
        M_WAIT  = 3'd2,
        M_STOP  = 3'd3,
        M_LEAVE = 3'd4,
        M_BACK  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        P_MIDDLE = 2'd0,
        P_LEFT   = 2'd1,
        P_RIGHT  = 2'd2
    } t_pos;

    typedef enum logic [2:0] {
        MV_STOPPED  = 3'd0,
        MV_TURN_NEG = 3'd1,
        MV_TURN_POS = 3'd2,
        MV_FORWARD  = 3'd3,
        MV_BACKWARD = 3'd4
    } t_move;

    // Every (vx, vw) pair the mode machine can command.
    typedef enum logic [3:0] {
        C_ZERO    = 4'd0,
        C_FWD     = 4'd1,
        C_LEFT    = 4'd2,
        C_RIGHT   = 4'd3,
        C_SPIN_L  = 4'd4,
        C_SPIN_R  = 4'd5,
        C_REVERSE = 4'd6,
        C_VEER_L  = 4'd7,
        C_VEER_R  = 4'd8
    } t_cmd;

    typedef struct packed {
        logic              lr;
        logic              rr;
        logic              m;
        logic              l;
        logic              r;
        logic [DIST_W-1:0] distance;
    } t_sense;

    typedef struct packed {
        logic road_flag;
        logic road_hold;
        logic middle_hold;
        logic wait_flag;
        logic side_right;
        t_pos pos;
    } t_det;

    typedef struct packed {
        logic              obst_en;
        logic [DIST_W-1:0] obst_mm;
        logic [DIST_W-1:0] near_mm;
        logic [STOP_W-1:0] stop_s;
    } t_cfg;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] ld;
        logic signed [DRIVE_W-1:0] rd;
        t_move                     mc;
    } t_drive;

    typedef struct packed {
        t_drive            drive;
        t_mode             mode;
        t_mode             prev_mode;
        logic              station;
        logic [REST_W-1:0] rest_s;
    } t_result;

    // Left drive is (vx+vw)*6/5, right drive is vx-vw.
    function automatic t_drive drive_of(t_cmd cmd);
        t_drive d;
        d = '{ld: '0, rd: '0, mc: MV_STOPPED};
        unique case (cmd)
            C_ZERO:    d = '{ld: 12'sd0,     rd: 12'sd0,     mc: MV_STOPPED};
            C_FWD:     d = '{ld: 12'sd600,   rd: 12'sd500,   mc: MV_FORWARD};
            C_LEFT:    d = '{ld: 12'sd720,   rd: 12'sd0,     mc: MV_TURN_POS};
            C_RIGHT:   d = '{ld: 12'sd0,     rd: 12'sd600,   mc: MV_TURN_NEG};
            C_SPIN_L:  d = '{ld: 12'sd720,   rd: -12'sd600,  mc: MV_TURN_POS};
            C_SPIN_R:  d = '{ld: -12'sd720,  rd: 12'sd600,   mc: MV_TURN_NEG};
            C_REVERSE: d = '{ld: -12'sd960,  rd: -12'sd800,  mc: MV_BACKWARD};
            C_VEER_L:  d = '{ld: 12'sd1320,  rd: -12'sd100,  mc: MV_TURN_POS};
            C_VEER_R:  d = '{ld: -12'sd120,  rd: 12'sd1100,  mc: MV_TURN_NEG};
            default:   d = '{ld: 12'sd0,     rd: 12'sd0,     mc: MV_STOPPED};
        endcase
        return d;
    endfunction

endpackage

[hdl/lfmc_detect.sv]
// Line detection: side-road memory, one-tick holds, position class and wait flag.
module lfmc_detect
    import lfmc_pkg::*;
(
    input  t_sense i_sense,
    input  t_det   i_cur,
    output t_det   o_next
);

    logic any_on;
    logic all_on;
    logic pos_upd;

    assign any_on = i_sense.lr | i_sense.rr | i_sense.m | i_sense.l | i_sense.r;
    assign all_on = i_sense.lr & i_sense.rr & i_sense.m & i_sense.l & i_sense.r;

    always_comb begin
        o_next = i_cur;
        pos_upd = 1'b0;
        if (i_cur.road_flag) begin
            if (i_sense.lr) begin
                o_next.side_right = 1'b0;
            end else if (i_sense.rr) begin
                o_next.side_right = 1'b1;
            end
        end
        if (all_on) begin
            o_next.wait_flag = 1'b1;
        end
        // A blank tick or an outer-only tick under middle_hold consumes a hold and keeps the class.
        if (any_on) begin
            if (i_sense.l | i_sense.r | i_sense.m) begin
                o_next.middle_hold = 1'b1;
                o_next.road_flag = 1'b1;
                o_next.road_hold = 1'b1;
                pos_upd = 1'b1;
            end else if (i_cur.middle_hold) begin
                o_next.middle_hold = 1'b0;
            end else begin
                o_next.road_flag = 1'b1;
                o_next.road_hold = 1'b1;
                pos_upd = 1'b1;
            end
        end else if (i_cur.road_hold) begin
            o_next.road_flag = 1'b1;
            o_next.road_hold = 1'b0;
        end else begin
            o_next.road_flag = 1'b0;
            o_next.road_hold = 1'b0;
        end
        if (pos_upd) begin
            priority if (i_sense.l) begin
                o_next.pos = P_LEFT;
            end else if (i_sense.r) begin
                o_next.pos = P_RIGHT;
            end else if ((i_sense.lr & i_sense.rr) | i_sense.m) begin
                o_next.pos = P_MIDDLE;
            end else if (i_sense.lr) begin
                o_next.pos = P_LEFT;
            end else if (i_sense.rr) begin
                o_next.pos = P_RIGHT;
            end
        end
    end

endmodule

[hdl/lfmc_core.sv]
// Mode state machine, stop timer and drive selection for one request per step.
`include "line_follower_mode_controller_top_macros.svh"

module lfmc_core
    import lfmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sense  i_sense,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_det              r_det, det_new, n_det;
    t_mode             r_mode, n_mode;
    t_mode             r_prev, n_prev;
    t_cmd              r_cmd, n_cmd;
    logic              r_offroad, n_offroad;
    logic              r_station, n_station;
    logic [SEC_W-1:0]  r_tmr_sec, n_tmr_sec;
    logic [FRAC_W-1:0] r_tmr_frac, n_tmr_frac;
    logic [REST_W-1:0] r_rest_s, n_rest_s;

    logic              all_on;
    logic              obst;
    logic              near;
    logic              tmr_wrap;
    logic [SEC_W-1:0]  inc_sec;
    logic [FRAC_W-1:0] inc_frac;
    logic              in_limit;

    lfmc_detect u_detect (
        .i_sense (i_sense),
        .i_cur   (r_det),
        .o_next  (det_new)
    );

    assign all_on = i_sense.lr & i_sense.rr & i_sense.m & i_sense.l & i_sense.r;
    assign obst = i_cfg.obst_en & (i_sense.distance < i_cfg.obst_mm);
    assign near = i_sense.distance < i_cfg.near_mm;

    // The stop timer counts ticks as whole seconds plus a sub-second count.
    assign tmr_wrap = (r_tmr_frac == FRAC_W'(TICKS_PER_SECOND - 1));
    assign inc_frac = tmr_wrap ? '0 : r_tmr_frac + 1'b1;
    assign inc_sec = tmr_wrap ? r_tmr_sec + 1'b1 : r_tmr_sec;
    assign in_limit = (inc_sec < {1'b0, i_cfg.stop_s})
                   || ((inc_sec == {1'b0, i_cfg.stop_s}) && (inc_frac == '0));

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            M_TRACK: begin
                if (obst) begin
                    n_mode = M_LEAVE;
                end else if (!det_new.road_flag) begin
                    if (r_offroad) begin
                        n_mode = M_TURN;
                    end
                end else if (det_new.wait_flag) begin
                    n_mode = M_WAIT;
                end
            end
            M_TURN: begin
                if (obst) begin
                    n_mode = M_LEAVE;
                end else if (i_sense.m) begin
                    n_mode = M_TRACK;
                end
            end
            M_STOP: begin
                if (!in_limit) begin
                    n_mode = M_TRACK;
                end
            end
            M_WAIT: begin
                n_mode = all_on ? M_STOP : M_TRACK;
            end
            M_LEAVE: begin
                if (!obst) begin
                    n_mode = M_BACK;
                end
            end
            M_BACK: begin
                if (obst) begin
                    n_mode = M_LEAVE;
                end else if (det_new.road_flag) begin
                    n_mode = M_TRACK;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    always_comb begin
        n_det = det_new;
        n_prev = r_prev;
        n_cmd = r_cmd;
        n_offroad = r_offroad;
        n_station = r_station;
        n_tmr_sec = r_tmr_sec;
        n_tmr_frac = r_tmr_frac;
        n_rest_s = r_rest_s;
        unique case (r_mode)
            M_TRACK: begin
                unique case (det_new.pos)
                    P_MIDDLE: n_cmd = C_FWD;
                    P_LEFT:   n_cmd = C_LEFT;
                    P_RIGHT:  n_cmd = C_RIGHT;
                    default:  n_cmd = r_cmd;
                endcase
                if (obst) begin
                    n_prev = M_TRACK;
                    if (near) begin
                        n_cmd = C_REVERSE;
                    end
                end else if (!det_new.road_flag) begin
                    n_prev = M_TRACK;
                    n_offroad = !r_offroad;
                end
            end
            M_TURN: begin
                n_cmd = det_new.side_right ? C_SPIN_R : C_SPIN_L;
                if (obst) begin
                    n_prev = M_TURN;
                    if (near) begin
                        n_cmd = C_REVERSE;
                    end
                end else if (i_sense.m) begin
                    n_prev = M_TURN;
                end
            end
            M_STOP: begin
                n_tmr_sec = inc_sec;
                n_tmr_frac = inc_frac;
                if (in_limit) begin
                    n_rest_s = inc_sec[REST_W-1:0];
                    n_cmd = C_ZERO;
                end else begin
                    n_station = 1'b0;
                    n_prev = M_STOP;
                end
            end
            M_WAIT: begin
                if (all_on) begin
                    n_station = 1'b1;
                    n_det.wait_flag = 1'b0;
                    n_tmr_sec = '0;
                    n_tmr_frac = '0;
                end
            end
            M_LEAVE: begin
                n_cmd = C_VEER_L;
                if (!obst) begin
                    n_prev = M_LEAVE;
                end
            end
            M_BACK: begin
                n_cmd = C_VEER_R;
                if (obst) begin
                    n_prev = M_BACK;
                    if (near) begin
                        n_cmd = C_REVERSE;
                    end
                end else if (det_new.road_flag) begin
                    n_prev = M_BACK;
                end
            end
            default: n_cmd = r_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det <= '{road_flag: 1'b1, road_hold: 1'b0, middle_hold: 1'b0,
                       wait_flag: 1'b0, side_right: 1'b0, pos: P_MIDDLE};
            r_mode <= M_TRACK;
            r_prev <= M_TRACK;
            r_cmd <= C_ZERO;
            r_offroad <= 1'b0;
            r_station <= 1'b0;
            r_tmr_sec <= '0;
            r_tmr_frac <= '0;
            r_rest_s <= '0;
        end else if (i_step) begin
            r_det <= n_det;
            r_mode <= n_mode;
            r_prev <= n_prev;
            r_cmd <= n_cmd;
            r_offroad <= n_offroad;
            r_station <= n_station;
            r_tmr_sec <= n_tmr_sec;
            r_tmr_frac <= n_tmr_frac;
            r_rest_s <= n_rest_s;
        end
    end

    assign o_res = '{drive: drive_of(n_cmd), mode: n_mode, prev_mode: n_prev,
                     station: n_station, rest_s: n_rest_s};

    `LFMC_ASSERT_IMP(a_station_in_stop, i_clk, i_rst_n, r_station, r_mode == M_STOP)
    `LFMC_ASSERT_NXT(a_hold_without_step, i_clk, i_rst_n, !i_step, $stable(r_mode) && $stable(r_cmd) && $stable(r_det))
    `LFMC_ASSERT_NXT(a_wait_one_tick, i_clk, i_rst_n, i_step && (r_mode == M_WAIT), (r_mode == M_STOP) || (r_mode == M_TRACK))

endmodule

[hdl/line_follower_mode_controller_top.sv]
// Top level of the line follower mode controller: stream ports, settings and pipeline registers.
//
//  Channel   Direction  Payload
//  s_axis    in         sensor bits and distance, one request per 1 ms tick
//  m_axis    out        drives, modes, direction class, station flag, stop seconds
//  cfg       in         obstacle_enable, obstacle_mm, near_mm, stop_seconds
//
// One request per clock while m_axis takes results; a result passes the input and then the output register to m_axis.
// The input register feeds the detection and mode logic, whose result lands in the output register.
// A full output register that is not taken stalls the input register, and s_axis tready drops while that is full.
// Reset is synchronous and active low and needs no clearing time.
module line_follower_mode_controller_top
    import lfmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] sense_left_road, [1] sense_right_road, [2] sense_middle, [3] sense_left,
    // [4] sense_right, [16:5] distance_mm, [23:17] zero
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [11:0] left_drive, [23:12] right_drive, [26:24] mode, [29:27] previous_mode,
    // [32:30] move_class, [33] at_station, [41:34] rest_seconds, [47:42] zero
    output logic [47:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata
);

    logic    r_in_valid, n_in_valid;
    logic    r_out_valid, n_out_valid;
    t_sense  r_in;
    t_result r_out;
    t_result core_res;
    t_cfg    r_cfg;
    logic    in_acc;
    logic    s1_adv;

    assign s1_adv = r_in_valid & (!r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid | s1_adv;
    assign in_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign n_in_valid = in_acc | (r_in_valid & !s1_adv);
    assign n_out_valid = s1_adv | (r_out_valid & !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= '{lr: i_s_axis_tdata[0], rr: i_s_axis_tdata[1], m: i_s_axis_tdata[2],
                      l: i_s_axis_tdata[3], r: i_s_axis_tdata[4],
                      distance: i_s_axis_tdata[16:5]};
        end
        if (s1_adv) begin
            r_out <= core_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{obst_en: 1'b0, obst_mm: 12'd200, near_mm: 12'd100, stop_s: 8'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_OBST_EN: r_cfg.obst_en <= i_cfg_wdata[0];
                CFG_OBST_MM: r_cfg.obst_mm <= i_cfg_wdata;
                CFG_NEAR_MM: r_cfg.near_mm <= i_cfg_wdata;
                CFG_STOP_S:  r_cfg.stop_s <= i_cfg_wdata[STOP_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    lfmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_adv),
        .i_sense (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {6'b0, r_out.rest_s, r_out.station, r_out.drive.mc,
                             r_out.prev_mode, r_out.mode, r_out.drive.rd, r_out.drive.ld};

endmodule
